>>> rtl/core/ksc_pkg.sv
// shared types and constants for the keyframe segment cutter
`timescale 1ns / 1ps
package ksc_pkg;

  localparam int unsigned SegmentLimitDef = 256;
  localparam int unsigned RingDepth       = 256;
  localparam int unsigned RingAw          = $clog2(RingDepth);
  localparam int unsigned CntW            = RingAw + 1;
  localparam int unsigned PtsW            = 33;
  localparam int unsigned TpsW            = 24;
  localparam int unsigned DurW            = 16;
  localparam int unsigned CfgDataW        = 24;

  typedef enum logic [1:0] {
    CfgSegSeconds = 2'd0,
    CfgMaxEntries = 2'd1,
    CfgTicksPerS  = 2'd2,
    CfgAudioEn    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KindVideo = 2'd0,
    KindAudio = 2'd1,
    KindOther = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_CMP,
    S_DIV,
    S_ROUND,
    S_PUSH,
    S_WALK,
    S_POST,
    S_OUT
  } state_e;

  typedef struct packed {
    logic            func;
    logic [1:0]      stream_kind;
    logic            key_frame;
    logic [PtsW-1:0] pts_ticks;
  } in_t;

  typedef struct packed {
    logic            forward;
    logic            cut;
    logic            evicted;
    logic            limit_reached;
    logic            final_flag;
    logic [DurW-1:0] seg_duration;
    logic [31:0]     list_first;
    logic [CntW-1:0] list_count;
    logic [DurW-1:0] peak_duration;
    logic [31:0]     segment_number;
  } out_t;

endpackage

>>> rtl/core/ksc_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ksc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ksc_pkg::PtsW-1:0] dividend_i,
  input  logic [ksc_pkg::TpsW-1:0] divisor_i,
  output logic                     done_o,
  output logic [ksc_pkg::PtsW-1:0] quot_o,
  output logic [ksc_pkg::TpsW-1:0] rem_o
);
  import ksc_pkg::*;

  localparam int unsigned CW = $clog2(PtsW + 1);

  logic [TpsW-1:0] rem_q, rem_d;
  logic [PtsW-1:0] quo_q, quo_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [TpsW:0]   trial;
  logic            ge;

  assign trial = {rem_q, quo_q[PtsW-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CW'(PtsW);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? TpsW'(trial - {1'b0, divisor_i}) : trial[TpsW-1:0];
      quo_d = {quo_q[PtsW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/keyframe_segment_cutter.sv
// keyframe segment cutter: packet gating, segment cuts and duration window
//
// input channel in_valid_i / in_stall_o carries one packet descriptor or an
// end-of-stream word; output channel out_valid_o / out_stall_i returns one
// result word per input word. config is written through cfg_we_i, cfg_idx_i
// and cfg_data_i; it must be written only while the block is idle, which
// the block itself does not enforce. a dropped or forwarded packet without
// a cut goes from accept through eval to output; a keyframe that is checked
// but not cut goes through eval, compare and output. end of stream with an
// open segment and a cut both use the shared divider for the rounded
// duration, then round, push, post and output. when the evicted duration
// equals the window maximum, the maximum is rebuilt by walking the ring one
// entry per cycle between push and post. one word is in work at a time;
// in_stall_o is high from accept until the result is loaded, so a new word
// is accepted only once the last result is loaded.
// the result register holds a word while out_stall_i is high, and the next
// input word can be accepted meanwhile; it waits at the end of its work
// until the register is free.
// reset brings back the register defaults, waits for the first keyframe and
// empties the window; the ring needs no clearing pass.
`timescale 1ns / 1ps
module keyframe_segment_cutter #(
  parameter int unsigned SegmentLimit = ksc_pkg::SegmentLimitDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [ksc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ksc_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ksc_pkg::out_t                out_data_o
);
  import ksc_pkg::*;

  state_e state_q, state_d;

  logic [11:0]     segs_q;
  logic [CntW-1:0] mle_q;
  logic [TpsW-1:0] tps_q;
  logic            aud_q;

  in_t             item_q, item_d;
  logic            waiting_q, waiting_d, halted_q, halted_d;
  logic [PtsW-1:0] start_q, start_d, prev_q, prev_d, last_q, last_d;
  logic [RingAw-1:0] head_q, head_d;
  logic [CntW-1:0] wc_q, wc_d;
  logic [31:0]     first_q, first_d, cur_q, cur_d;
  logic [DurW-1:0] wmax_q, wmax_d, dur_q, dur_d;
  logic            cut_q, cut_d, fwd_q, fwd_d, ev_q, ev_d, lim_q, lim_d, fin_q, fin_d;
  logic            zero_q, zero_d;
  logic [37:0]     mul_q, mul_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  out_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic [DurW-1:0]   ring [RingDepth];
  logic              mem_we, mem_re;
  logic [RingAw-1:0] mem_waddr, mem_raddr;
  logic [DurW-1:0]   mem_wdata, rd_q;

  logic            div_start, div_done;
  logic [PtsW-1:0] div_dividend, div_quot;
  logic [TpsW-1:0] div_rem;

  logic [TpsW-1:0] tps_eff;
  logic            is_video, is_audio;
  logic signed [40:0] cmp_lhs;
  logic [33:0]     elapsed;
  logic [PtsW:0]   q_inc;
  logic [TpsW:0]   rem2;
  logic            round_up;
  logic [DurW-1:0] dur_rnd, mx;
  logic [CntW-1:0] len, wc_n;
  logic [RingAw-1:0] head_n;
  logic            evict, walk_w;

  assign tps_eff  = (tps_q == '0) ? TpsW'(1) : tps_q;
  assign is_video = item_q.stream_kind == KindVideo;
  assign is_audio = item_q.stream_kind == KindAudio;
  assign elapsed  = {1'b0, item_q.pts_ticks} - {1'b0, start_q};
  assign cmp_lhs  = $signed({{5{elapsed[33]}}, elapsed, 2'b00}) +
                    $signed({17'd0, tps_eff});
  assign rem2     = {div_rem, 1'b0};
  assign round_up = (rem2 > {1'b0, tps_eff}) || ((rem2 == {1'b0, tps_eff}) && div_quot[0]);
  assign q_inc    = {1'b0, div_quot} + {{PtsW{1'b0}}, round_up};
  assign dur_rnd  = zero_q ? '0 :
                    (q_inc > (PtsW + 1)'(16'hFFFF)) ? 16'hFFFF : q_inc[DurW-1:0];
  assign len      = ((mle_q == '0) || (mle_q > CntW'(RingDepth))) ? CntW'(RingDepth) : mle_q;
  assign evict    = ((wc_q >= CntW'(RingDepth)) ||
                     (!item_q.func && ({1'b0, wc_q} + 1'b1 > {1'b0, len}))) && (wc_q != '0);
  assign head_n   = evict ? head_q + 1'b1 : head_q;
  assign wc_n     = evict ? wc_q - 1'b1 : wc_q;
  assign mx       = (dur_q > wmax_q) ? dur_q : wmax_q;
  assign walk_w   = pend_q && (rd_q > wmax_q);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    waiting_d    = waiting_q;
    halted_d     = halted_q;
    start_d      = start_q;
    prev_d       = prev_q;
    last_d       = last_q;
    head_d       = head_q;
    wc_d         = wc_q;
    first_d      = first_q;
    cur_d        = cur_q;
    wmax_d       = wmax_q;
    dur_d        = dur_q;
    cut_d        = cut_q;
    fwd_d        = fwd_q;
    ev_d         = ev_q;
    lim_d        = lim_q;
    fin_d        = fin_q;
    zero_d       = zero_q;
    mul_d        = mul_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_we       = 1'b0;
    mem_waddr    = head_n + wc_n[RingAw-1:0];
    mem_wdata    = dur_q;
    mem_re       = 1'b0;
    mem_raddr    = head_q;
    div_start    = 1'b0;
    div_dividend = last_q - start_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          cut_d   = 1'b0;
          fwd_d   = 1'b0;
          ev_d    = 1'b0;
          lim_d   = 1'b0;
          fin_d   = 1'b0;
          dur_d   = '0;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_OUT;
        if (halted_q) begin
          state_d = S_OUT;
        end else if (item_q.func) begin
          if (!waiting_q) begin
            div_start = 1'b1;
            zero_d    = last_q <= start_q;
            state_d   = S_DIV;
          end else begin
            halted_d = 1'b1;
          end
        end else if (is_video || (is_audio && aud_q)) begin
          if (is_video) begin
            last_d = item_q.pts_ticks;
            if (item_q.key_frame && waiting_q) begin
              waiting_d = 1'b0;
              prev_d    = item_q.pts_ticks;
              start_d   = item_q.pts_ticks;
            end
          end
          if (waiting_q && !(is_video && item_q.key_frame)) begin
            state_d = S_OUT;
          end else if (is_video && item_q.key_frame) begin
            mul_d   = 38'(tps_eff) * 38'({segs_q, 2'b00});
            state_d = S_CMP;
          end else begin
            fwd_d = 1'b1;
            if (is_video) begin
              prev_d = item_q.pts_ticks;
            end
          end
        end
      end
      S_CMP: begin
        if (cmp_lhs >= $signed({3'b000, mul_q})) begin
          cut_d        = 1'b1;
          div_start    = 1'b1;
          div_dividend = prev_q - start_q;
          zero_d       = prev_q <= start_q;
          state_d      = S_DIV;
        end else begin
          fwd_d   = 1'b1;
          prev_d  = item_q.pts_ticks;
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        dur_d   = (item_q.func && dur_rnd == '0) ? DurW'(1) : dur_rnd;
        mem_re  = 1'b1;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        mem_we  = 1'b1;
        head_d  = head_n;
        wc_d    = wc_n + 1'b1;
        first_d = evict ? first_q + 1'b1 : first_q;
        wmax_d  = mx;
        ev_d    = evict;
        state_d = S_POST;
        if (evict && rd_q == mx) begin
          wmax_d  = '0;
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_w) begin
          wmax_d = rd_q;
        end
        mem_raddr = head_q + idx_q[RingAw-1:0];
        if (idx_q < wc_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_POST;
          end
        end
      end
      S_POST: begin
        state_d = S_OUT;
        if (item_q.func) begin
          fin_d    = 1'b1;
          halted_d = 1'b1;
        end else if (32'(wc_q) >= 32'(SegmentLimit)) begin
          lim_d    = 1'b1;
          halted_d = 1'b1;
        end else begin
          cur_d   = cur_q + 1'b1;
          start_d = item_q.pts_ticks;
          fwd_d   = 1'b1;
          prev_d  = item_q.pts_ticks;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.forward        = fwd_q;
          out_d.cut            = cut_q;
          out_d.evicted        = ev_q;
          out_d.limit_reached  = lim_q;
          out_d.final_flag     = fin_q;
          out_d.seg_duration   = dur_q;
          out_d.list_first     = first_q;
          out_d.list_count     = wc_q;
          out_d.peak_duration  = wmax_q;
          out_d.segment_number = cur_q;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      segs_q      <= 12'd10;
      mle_q       <= '0;
      tps_q       <= TpsW'(90000);
      aud_q       <= 1'b1;
      waiting_q   <= 1'b1;
      halted_q    <= 1'b0;
      start_q     <= '0;
      prev_q      <= '0;
      last_q      <= '0;
      head_q      <= '0;
      wc_q        <= '0;
      first_q     <= 32'd1;
      wmax_q      <= '0;
      cur_q       <= 32'd1;
      pend_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      waiting_q   <= waiting_d;
      halted_q    <= halted_d;
      start_q     <= start_d;
      prev_q      <= prev_d;
      last_q      <= last_d;
      head_q      <= head_d;
      wc_q        <= wc_d;
      first_q     <= first_d;
      wmax_q      <= wmax_d;
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgSegSeconds: segs_q <= cfg_data_i[11:0];
          CfgMaxEntries: mle_q  <= cfg_data_i[CntW-1:0];
          CfgTicksPerS:  tps_q  <= cfg_data_i[TpsW-1:0];
          CfgAudioEn:    aud_q  <= cfg_data_i[0];
          default:       aud_q  <= aud_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    dur_q  <= dur_d;
    cut_q  <= cut_d;
    fwd_q  <= fwd_d;
    ev_q   <= ev_d;
    lim_q  <= lim_d;
    fin_q  <= fin_d;
    zero_q <= zero_d;
    mul_q  <= mul_d;
    out_q  <= out_d;
  end

  // duration ring, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= ring[mem_raddr];
    end
  end

  ksc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (tps_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt state left");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= CntW'(RingDepth)) else $error("window count beyond ring");

  a_limit_no_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.limit_reached |-> !out_data_o.forward && out_data_o.cut)
    else $error("limit word forwarded");

endmodule
